@@ hdl/pb52_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pb52_pkg
// Shared types, constants and lookup functions for the base-52 PIN codec:
// operation codes, the letter alphabet and the reciprocal constants used for
// division by fixed radices.
// ----------------------------------------------------------------------------
package pb52_pkg;

  typedef enum logic [1:0] {
    FUNC_ENCODE  = 2'd0,
    FUNC_DECODE  = 2'd1,
    FUNC_COMPARE = 2'd2
  } func_e;

  localparam int unsigned NUM_CHARS = 6;
  localparam int unsigned RADIX     = 52;
  localparam int unsigned MILLION   = 1000000;
  localparam int unsigned SALT_MOD  = 2146;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [7:0] ALPHABET [RADIX] = '{
    "A", "z", "C", "s", "E", "k", "G", "r", "I", "y",
    "K", "u", "M", "q", "O", "n", "Q", "l", "S", "f",
    "U", "h", "W", "c", "Y", "a", "Z", "b", "X", "d",
    "e", "T", "g", "V", "i", "j", "F", "p", "m", "P",
    "o", "N", "R", "H", "D", "t", "L", "v", "w", "B",
    "J", "x"
  };

  // 52^k reduced modulo one million, one weight per letter position
  localparam logic [19:0] POS_WEIGHT [NUM_CHARS] = '{
    20'(64'd1 % 64'd1000000),
    20'(64'd52 % 64'd1000000),
    20'(64'd2704 % 64'd1000000),
    20'(64'd140608 % 64'd1000000),
    20'(64'd7311616 % 64'd1000000),
    20'(64'd380204032 % 64'd1000000)
  };

  // exact division of a 31-bit value by 52^k, k = 1..5
  localparam int unsigned ENC_SH  [5] = '{37, 43, 49, 54, 60};
  localparam logic [31:0] ENC_MUL [5] = '{
    32'(((64'd1 << 37) + 64'd52 - 64'd1) / 64'd52),
    32'(((64'd1 << 43) + 64'd2704 - 64'd1) / 64'd2704),
    32'(((64'd1 << 49) + 64'd140608 - 64'd1) / 64'd140608),
    32'(((64'd1 << 54) + 64'd7311616 - 64'd1) / 64'd7311616),
    32'(((64'd1 << 60) + 64'd380204032 - 64'd1) / 64'd380204032)
  };

  // exact division of a 20-bit value by 10^k, k = 1..5
  localparam int unsigned DEC_SH  [5] = '{24, 27, 30, 34, 37};
  localparam logic [20:0] DEC_MUL [5] = '{
    21'(((64'd1 << 24) + 64'd10 - 64'd1) / 64'd10),
    21'(((64'd1 << 27) + 64'd100 - 64'd1) / 64'd100),
    21'(((64'd1 << 30) + 64'd1000 - 64'd1) / 64'd1000),
    21'(((64'd1 << 34) + 64'd10000 - 64'd1) / 64'd10000),
    21'(((64'd1 << 37) + 64'd100000 - 64'd1) / 64'd100000)
  };

  // quotient estimate for division by one million, low by at most one
  localparam int unsigned MOD_SH  = 48;
  localparam logic [28:0] MOD_MUL = 29'((64'd1 << 48) / 64'd1000000);

  function automatic logic [5:0] letter_index(input logic [7:0] c);
    logic [5:0] idx;
    idx = 6'(RADIX);
    for (int m = RADIX - 1; m >= 0; m--) begin
      if (ALPHABET[m] == c) begin
        idx = 6'(m);
      end
    end
    return idx;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [5:0] d);
    logic [7:0] ch;
    ch = '0;
    if (d < 6'(RADIX)) begin
      ch = ALPHABET[d];
    end
    return ch;
  endfunction

  function automatic logic [16:0] dec_weight(input logic [2:0] len, input logic [2:0] pos);
    logic [16:0] w;
    w = '0;
    if (pos < len) begin
      case (3'(len - pos - 3'd1))
        3'd0:    w = 17'd1;
        3'd1:    w = 17'd10;
        3'd2:    w = 17'd100;
        3'd3:    w = 17'd1000;
        3'd4:    w = 17'd10000;
        3'd5:    w = 17'd100000;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

endpackage

@@ hdl/pin_base52_letter_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pin_base52_letter_codec
// Six-character PIN codec: encode a salted decimal PIN into base-52 letters,
// decode letters back to six decimal digits, or compare two operands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries func_i, text_a_i, text_b_i
//   and salt_i; output channel out_valid_o / out_ready_i carries
//   result_text_o and mismatch_o. Every input transaction gives exactly one
//   output transaction, in order.
//   The datapath is a six-stage pipeline: parse and letter lookup, weighted
//   sums, salt product and modulo estimate, reciprocal-multiply quotients,
//   digit extraction, and final formatting with compare. One transaction is
//   taken every cycle while the output stage is not held by out_ready_i.
//   Each stage holds its own valid bit and moves forward whenever the stage
//   after it is empty or moving, so bubbles close up. When the receiver holds
//   out_ready_i low the output stage holds its result and the pipeline keeps
//   filling; in_ready_o drops only once all six stages are occupied.
//   Reset clears all valid bits; the pipeline is empty after reset and no
//   transaction is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module pin_base52_letter_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [47:0] text_a_i,
  input  logic [47:0] text_b_i,
  input  logic [11:0] salt_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] result_text_o,
  output logic        mismatch_o
);

  localparam int unsigned NC = pb52_pkg::NUM_CHARS;

  logic [5:0] valid_q;
  logic [5:0] rdy;
  logic [5:0] vin;

  // pipeline flow control
  always_comb begin
    rdy[5] = !valid_q[5] || out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin = {valid_q[4:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < 6; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[5];

  // stage 1: digit scan, letter lookup, salt reduction
  logic [3:0]  s1_dig_d   [NC];
  logic [5:0]  s1_idx_a_d [NC];
  logic [5:0]  s1_idx_b_d [NC];
  logic [2:0]  s1_len_d;
  logic        s1_run;
  logic [11:0] s1_salt_d;

  always_comb begin
    s1_run   = 1'b1;
    s1_len_d = '0;
    for (int k = 0; k < NC; k++) begin
      s1_dig_d[k]   = 4'(text_a_i[8*k +: 8] - pb52_pkg::CHAR_ZERO);
      s1_idx_a_d[k] = pb52_pkg::letter_index(text_a_i[8*k +: 8]);
      s1_idx_b_d[k] = pb52_pkg::letter_index(text_b_i[8*k +: 8]);
      if (s1_run && text_a_i[8*k +: 8] >= pb52_pkg::CHAR_ZERO &&
          text_a_i[8*k +: 8] <= pb52_pkg::CHAR_NINE) begin
        s1_len_d = s1_len_d + 3'd1;
      end else begin
        s1_run = 1'b0;
      end
    end
    if (salt_i >= 12'(pb52_pkg::SALT_MOD)) begin
      s1_salt_d = salt_i - 12'(pb52_pkg::SALT_MOD);
    end else begin
      s1_salt_d = salt_i;
    end
  end

  logic [1:0]  s1_func_q;
  logic [47:0] s1_text_a_q, s1_text_b_q;
  logic [11:0] s1_salt_q;
  logic [3:0]  s1_dig_q   [NC];
  logic [5:0]  s1_idx_a_q [NC];
  logic [5:0]  s1_idx_b_q [NC];
  logic [2:0]  s1_len_q;
  logic        s1_dec_a_q, s1_dec_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      s1_func_q   <= func_i;
      s1_text_a_q <= text_a_i;
      s1_text_b_q <= text_b_i;
      s1_salt_q   <= s1_salt_d;
      s1_dig_q    <= s1_dig_d;
      s1_idx_a_q  <= s1_idx_a_d;
      s1_idx_b_q  <= s1_idx_b_d;
      s1_len_q    <= s1_len_d;
      s1_dec_a_q  <= text_a_i[7:0] > pb52_pkg::CHAR_NINE;
      s1_dec_b_q  <= text_b_i[7:0] > pb52_pkg::CHAR_NINE;
    end
  end

  // stage 2: pin value and weighted letter sums
  logic [19:0] s2_p_d;
  logic [28:0] s2_sum_a_d, s2_sum_b_d;

  always_comb begin
    s2_p_d     = '0;
    s2_sum_a_d = '0;
    s2_sum_b_d = '0;
    for (int k = 0; k < NC; k++) begin
      s2_p_d = s2_p_d + 20'(21'(s1_dig_q[k]) * 21'(pb52_pkg::dec_weight(s1_len_q, 3'(k))));
      s2_sum_a_d = s2_sum_a_d + 29'(26'(s1_idx_a_q[k]) * 26'(pb52_pkg::POS_WEIGHT[k]));
      s2_sum_b_d = s2_sum_b_d + 29'(26'(s1_idx_b_q[k]) * 26'(pb52_pkg::POS_WEIGHT[k]));
    end
  end

  logic [1:0]  s2_func_q;
  logic [47:0] s2_text_a_q, s2_text_b_q;
  logic [11:0] s2_salt_q;
  logic [19:0] s2_p_q;
  logic [28:0] s2_sum_a_q, s2_sum_b_q;
  logic        s2_dec_a_q, s2_dec_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      s2_func_q   <= s1_func_q;
      s2_text_a_q <= s1_text_a_q;
      s2_text_b_q <= s1_text_b_q;
      s2_salt_q   <= s1_salt_q;
      s2_p_q      <= s2_p_d;
      s2_sum_a_q  <= s2_sum_a_d;
      s2_sum_b_q  <= s2_sum_b_d;
      s2_dec_a_q  <= s1_dec_a_q;
      s2_dec_b_q  <= s1_dec_b_q;
    end
  end

  // stage 3: salted value and quotient estimate by one million
  logic [30:0] s3_v_d;
  logic [8:0]  s3_qa_d, s3_qb_d;

  always_comb begin
    s3_v_d  = 31'(32'(s2_salt_q) * 32'(pb52_pkg::MILLION)) + 31'(s2_p_q);
    s3_qa_d = 9'((64'(s2_sum_a_q) * 64'(pb52_pkg::MOD_MUL)) >> pb52_pkg::MOD_SH);
    s3_qb_d = 9'((64'(s2_sum_b_q) * 64'(pb52_pkg::MOD_MUL)) >> pb52_pkg::MOD_SH);
  end

  logic [1:0]  s3_func_q;
  logic [47:0] s3_text_a_q, s3_text_b_q;
  logic [30:0] s3_v_q;
  logic [8:0]  s3_qa_q, s3_qb_q;
  logic [28:0] s3_sum_a_q, s3_sum_b_q;
  logic        s3_dec_a_q, s3_dec_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      s3_func_q   <= s2_func_q;
      s3_text_a_q <= s2_text_a_q;
      s3_text_b_q <= s2_text_b_q;
      s3_v_q      <= s3_v_d;
      s3_qa_q     <= s3_qa_d;
      s3_qb_q     <= s3_qb_d;
      s3_sum_a_q  <= s2_sum_a_q;
      s3_sum_b_q  <= s2_sum_b_q;
      s3_dec_a_q  <= s2_dec_a_q;
      s3_dec_b_q  <= s2_dec_b_q;
    end
  end

  // stage 4: base-52 quotients, remainder modulo one million
  logic [30:0] s4_encq_d [NC];
  logic [28:0] s4_diff_a, s4_diff_b;
  logic [19:0] s4_ra_d, s4_rb_d;

  always_comb begin
    s4_encq_d[0] = s3_v_q;
    for (int i = 0; i < 5; i++) begin
      s4_encq_d[i+1] = 31'((64'(s3_v_q) * 64'(pb52_pkg::ENC_MUL[i])) >> pb52_pkg::ENC_SH[i]);
    end
    s4_diff_a = s3_sum_a_q - 29'(38'(s3_qa_q) * 38'(pb52_pkg::MILLION));
    s4_diff_b = s3_sum_b_q - 29'(38'(s3_qb_q) * 38'(pb52_pkg::MILLION));
    if (s4_diff_a >= 29'(pb52_pkg::MILLION)) begin
      s4_ra_d = 20'(s4_diff_a - 29'(pb52_pkg::MILLION));
    end else begin
      s4_ra_d = 20'(s4_diff_a);
    end
    if (s4_diff_b >= 29'(pb52_pkg::MILLION)) begin
      s4_rb_d = 20'(s4_diff_b - 29'(pb52_pkg::MILLION));
    end else begin
      s4_rb_d = 20'(s4_diff_b);
    end
  end

  logic [1:0]  s4_func_q;
  logic [47:0] s4_text_a_q, s4_text_b_q;
  logic [30:0] s4_encq_q [NC];
  logic [19:0] s4_ra_q, s4_rb_q;
  logic        s4_dec_a_q, s4_dec_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vin[3]) begin
      s4_func_q   <= s3_func_q;
      s4_text_a_q <= s3_text_a_q;
      s4_text_b_q <= s3_text_b_q;
      s4_encq_q   <= s4_encq_d;
      s4_ra_q     <= s4_ra_d;
      s4_rb_q     <= s4_rb_d;
      s4_dec_a_q  <= s3_dec_a_q;
      s4_dec_b_q  <= s3_dec_b_q;
    end
  end

  // stage 5: letters from base-52 digits, decimal quotients
  logic [47:0] s5_enc_d;
  logic [5:0]  s5_dgt;
  logic [19:0] s5_decq_a_d [NC];
  logic [19:0] s5_decq_b_d [NC];

  always_comb begin
    for (int k = 0; k < NC - 1; k++) begin
      s5_dgt = 6'(s4_encq_q[k] - 31'(s4_encq_q[k+1] * 31'(pb52_pkg::RADIX)));
      s5_enc_d[8*k +: 8] = pb52_pkg::alpha_char(s5_dgt);
    end
    s5_dgt = 6'(s4_encq_q[NC-1]);
    s5_enc_d[8*(NC-1) +: 8] = pb52_pkg::alpha_char(s5_dgt);
    s5_decq_a_d[0] = s4_ra_q;
    s5_decq_b_d[0] = s4_rb_q;
    for (int i = 0; i < 5; i++) begin
      s5_decq_a_d[i+1] = 20'((64'(s4_ra_q) * 64'(pb52_pkg::DEC_MUL[i])) >> pb52_pkg::DEC_SH[i]);
      s5_decq_b_d[i+1] = 20'((64'(s4_rb_q) * 64'(pb52_pkg::DEC_MUL[i])) >> pb52_pkg::DEC_SH[i]);
    end
  end

  logic [1:0]  s5_func_q;
  logic [47:0] s5_text_a_q, s5_text_b_q;
  logic [47:0] s5_enc_q;
  logic [19:0] s5_decq_a_q [NC];
  logic [19:0] s5_decq_b_q [NC];
  logic        s5_dec_a_q, s5_dec_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4] && vin[4]) begin
      s5_func_q   <= s4_func_q;
      s5_text_a_q <= s4_text_a_q;
      s5_text_b_q <= s4_text_b_q;
      s5_enc_q    <= s5_enc_d;
      s5_decq_a_q <= s5_decq_a_d;
      s5_decq_b_q <= s5_decq_b_d;
      s5_dec_a_q  <= s4_dec_a_q;
      s5_dec_b_q  <= s4_dec_b_q;
    end
  end

  // stage 6: decimal text, compare, result select
  logic [3:0]  s6_dd_a [NC];
  logic [3:0]  s6_dd_b [NC];
  logic [47:0] s6_dtext_a, s6_dtext_b;
  logic [47:0] s6_norm_a, s6_norm_b;
  logic        s6_done, s6_mis;
  logic [47:0] s6_text_d;
  logic        s6_mis_d;

  always_comb begin
    for (int i = 0; i < NC - 1; i++) begin
      s6_dd_a[i] = 4'(s5_decq_a_q[i] - 20'(s5_decq_a_q[i+1] * 20'd10));
      s6_dd_b[i] = 4'(s5_decq_b_q[i] - 20'(s5_decq_b_q[i+1] * 20'd10));
    end
    s6_dd_a[NC-1] = 4'(s5_decq_a_q[NC-1]);
    s6_dd_b[NC-1] = 4'(s5_decq_b_q[NC-1]);
    for (int j = 0; j < NC; j++) begin
      s6_dtext_a[8*j +: 8] = pb52_pkg::CHAR_ZERO + 8'(s6_dd_a[NC-1-j]);
      s6_dtext_b[8*j +: 8] = pb52_pkg::CHAR_ZERO + 8'(s6_dd_b[NC-1-j]);
    end
    s6_norm_a = s5_dec_a_q ? s6_dtext_a : s5_text_a_q;
    s6_norm_b = s5_dec_b_q ? s6_dtext_b : s5_text_b_q;
    s6_done = 1'b0;
    s6_mis  = 1'b0;
    for (int k = 0; k < NC; k++) begin
      if (!s6_done) begin
        if (s6_norm_a[8*k +: 8] != s6_norm_b[8*k +: 8]) begin
          s6_mis  = 1'b1;
          s6_done = 1'b1;
        end else if (s6_norm_a[8*k +: 8] == 8'h00) begin
          s6_done = 1'b1;
        end
      end
    end
    case (s5_func_q)
      pb52_pkg::FUNC_ENCODE: begin
        s6_text_d = s5_enc_q;
        s6_mis_d  = 1'b0;
      end
      pb52_pkg::FUNC_DECODE: begin
        s6_text_d = s6_dtext_a;
        s6_mis_d  = 1'b0;
      end
      pb52_pkg::FUNC_COMPARE: begin
        s6_text_d = '0;
        s6_mis_d  = s6_mis;
      end
      default: begin
        s6_text_d = '0;
        s6_mis_d  = 1'b0;
      end
    endcase
  end

  logic [47:0] s6_text_q;
  logic        s6_mis_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && vin[5]) begin
      s6_text_q <= s6_text_d;
      s6_mis_q  <= s6_mis_d;
    end
  end

  assign result_text_o = s6_text_q;
  assign mismatch_o    = s6_mis_q;

endmodule
